// File: design/mmb_pkg.sv
// shared types and constants for the bounded matrix multiply block
package mmb_pkg;

  localparam int unsigned DEF_MAX_M = 64;
  localparam int unsigned DEF_MAX_K = 64;
  localparam int unsigned DEF_MAX_N = 64;

  localparam int unsigned REG_W   = 7;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned SUM_W   = 38;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd2;

  localparam logic [REG_W-1:0] SIZE_RESET = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;
  } mmb_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] product_sum;
    logic                    in_range;
  } mmb_out_t;

  // classified request passed from the front part to the back part
  typedef struct packed {
    logic                     is_write_a;
    logic                     is_write_b;
    logic                     in_range;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;
    logic [REG_W:0]           term_count;
  } mmb_job_t;

endpackage

// File: design/mmb_front.sv
// front part: accepts requests, bounds-checks them and queues classified jobs
module mmb_front
  import mmb_pkg::*;
#(
  parameter int unsigned MAX_M = DEF_MAX_M,
  parameter int unsigned MAX_K = DEF_MAX_K,
  parameter int unsigned MAX_N = DEF_MAX_N,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mmb_in_t        in_data,
  input  logic [REG_W-1:0] rows_m,
  input  logic [REG_W-1:0] inner_k,
  input  logic [REG_W-1:0] cols_n,
  output logic           job_valid,
  input  logic           job_take,
  output mmb_job_t       job
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  // a limit above the largest register value never bites
  localparam int unsigned REG_MAX = (1 << REG_W) - 1;
  localparam logic [REG_W:0] LIM_M = (REG_W+1)'((MAX_M > REG_MAX) ? REG_MAX : MAX_M);
  localparam logic [REG_W:0] LIM_K = (REG_W+1)'((MAX_K > REG_MAX) ? REG_MAX : MAX_K);
  localparam logic [REG_W:0] LIM_N = (REG_W+1)'((MAX_N > REG_MAX) ? REG_MAX : MAX_N);

  mmb_job_t       queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  logic [REG_W:0] m_eff, k_eff, n_eff;
  logic [REG_W:0] row_x, col_x;
  logic           push, pop;
  mmb_job_t       new_job;

  // clamp configured sizes to the built maximum
  always_comb begin
    m_eff = ({1'b0, rows_m}  > LIM_M) ? LIM_M : {1'b0, rows_m};
    k_eff = ({1'b0, inner_k} > LIM_K) ? LIM_K : {1'b0, inner_k};
    n_eff = ({1'b0, cols_n}  > LIM_N) ? LIM_N : {1'b0, cols_n};
    row_x = {2'b00, in_data.row_index};
    col_x = {2'b00, in_data.col_index};
  end

  // classify the incoming request
  always_comb begin
    new_job = '0;
    new_job.row_index  = in_data.row_index;
    new_job.col_index  = in_data.col_index;
    new_job.elem_value = in_data.elem_value;
    new_job.term_count = k_eff;
    case (in_data.command)
      CMD_WRITE_A: new_job.is_write_a = (row_x < m_eff) && (col_x < k_eff);
      CMD_WRITE_B: new_job.is_write_b = (row_x < k_eff) && (col_x < n_eff);
      default:     new_job.in_range   = (row_x < m_eff) && (col_x < n_eff);
    endcase
  end

  assign in_stall  = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  // reads always make a job; dropped writes and unused commands do not
  assign push = in_valid && !in_stall &&
                ((in_data.command == CMD_READ) || new_job.is_write_a || new_job.is_write_b);
  assign job_valid = (fill != '0);
  assign pop  = job_valid && job_take;
  assign job  = queue[rd_ptr];

  // job queue
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// File: design/mmb_back.sv
// back part: element stores and the multiply-accumulate sequencer
module mmb_back
  import mmb_pkg::*;
#(
  parameter int unsigned MAX_M = DEF_MAX_M,
  parameter int unsigned MAX_K = DEF_MAX_K,
  parameter int unsigned MAX_N = DEF_MAX_N
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  output logic     job_take,
  input  mmb_job_t job,
  output logic     out_valid,
  input  logic     out_stall,
  output mmb_out_t out_data
);

  localparam int unsigned A_DEPTH = MAX_M * MAX_K;
  localparam int unsigned B_DEPTH = MAX_K * MAX_N;
  localparam int unsigned A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int unsigned B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int unsigned T_W  = REG_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_t;

  logic signed [ELEM_W-1:0] mem_a [A_DEPTH];
  logic signed [ELEM_W-1:0] mem_b [B_DEPTH];
  logic signed [ELEM_W-1:0] a_rd, b_rd;

  state_t         state;
  logic [T_W-1:0] term;
  logic [T_W-1:0] term_count;
  logic [IDX_W-1:0] row_q, col_q;
  logic           rd_live;
  logic           mul_live;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic [A_AW-1:0] a_addr;
  logic [B_AW-1:0] b_addr;
  logic [A_AW-1:0] a_waddr;
  logic [B_AW-1:0] b_waddr;
  logic            start;

  // store addresses: row-major with fixed strides
  always_comb begin
    a_waddr = A_AW'(32'(job.row_index) * MAX_K + 32'(job.col_index));
    b_waddr = B_AW'(32'(job.row_index) * MAX_N + 32'(job.col_index));
    a_addr  = A_AW'(32'(row_q) * MAX_K + 32'(term));
    b_addr  = B_AW'(32'(term) * MAX_N + 32'(col_q));
  end

  assign job_take = (state == S_IDLE) && job_valid;
  assign start    = job_take && !job.is_write_a && !job.is_write_b;
  assign out_valid = (state == S_OUT);

  // element stores with registered reads
  always_ff @(posedge clk) begin
    if (job_take && job.is_write_a) mem_a[a_waddr] <= job.elem_value;
    if (job_take && job.is_write_b) mem_b[b_waddr] <= job.elem_value;
    a_rd <= mem_a[a_addr];
    b_rd <= mem_b[b_addr];
  end

  // sequencer: read, multiply, accumulate one term per cycle
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a_rd) * PROD_W'(b_rd);
    if (rst) begin
      state    <= S_IDLE;
      rd_live  <= 1'b0;
      mul_live <= 1'b0;
    end else begin
      mul_live <= rd_live;
      if (mul_live) acc <= acc + SUM_W'(prod);
      unique case (state)
        S_IDLE: begin
          rd_live <= 1'b0;
          if (start) begin
            row_q      <= job.row_index;
            col_q      <= job.col_index;
            term       <= '0;
            term_count <= job.in_range ? job.term_count : '0;
            acc        <= '0;
            out_data.in_range <= job.in_range;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (term < term_count) begin
            rd_live <= 1'b1;
            term    <= term + 1'b1;
          end else begin
            rd_live <= 1'b0;
            state   <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_live && !mul_live) begin
            out_data.product_sum <= mul_live ? acc + SUM_W'(prod) : acc;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/matrix_multiply_bounded_unit.sv
// top level of the bounded matrix multiply block
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    mmb_in_t  (command, indices, value)
//  out       output     out_valid / out_stall  mmb_out_t (product_sum, in_range)
//  cfg       input      cfg_write              cfg_index, cfg_data
//
// writes: stored as the back part takes them, which leaves it idle; dropped writes cost nothing there
// reads: handled one at a time by the single multiply-accumulate loop
// reset clears control and size registers to 64; stores are undefined
// the job queue lets requests arrive while a read still runs or waits on out_stall
module matrix_multiply_bounded_unit
  import mmb_pkg::*;
#(
  parameter int unsigned MAX_M = DEF_MAX_M,
  parameter int unsigned MAX_K = DEF_MAX_K,
  parameter int unsigned MAX_N = DEF_MAX_N
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mmb_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmb_out_t             out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic [REG_W-1:0] rows_m, inner_k, cols_n;
  logic     job_valid, job_take;
  mmb_job_t job;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= SIZE_RESET;
      inner_k <= SIZE_RESET;
      cols_n  <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS_M:  rows_m  <= cfg_data;
        REG_INNER_K: inner_k <= cfg_data;
        REG_COLS_N:  cols_n  <= cfg_data;
        default: ;
      endcase
    end
  end

  mmb_front #(.MAX_M(MAX_M), .MAX_K(MAX_K), .MAX_N(MAX_N)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .rows_m(rows_m), .inner_k(inner_k), .cols_n(cols_n),
    .job_valid(job_valid), .job_take(job_take), .job(job)
  );

  mmb_back #(.MAX_M(MAX_M), .MAX_K(MAX_K), .MAX_N(MAX_N)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_take(job_take), .job(job),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

`ifndef SYNTHESIS
  // an out-of-range read always reports a zero sum
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.in_range |-> out_data.product_sum == '0)
    else $error("out-of-range read with nonzero sum");
  // a result waiting on out_stall keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  // the back part takes no job while a result is pending
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !job_take)
    else $error("job taken while result pending");
`endif

endmodule

// File: verif/mmb_checker.sv
// checker for the bounded matrix multiply block: tracks stores and sizes, predicts and compares
`timescale 1ns / 1ps
module mmb_checker
  import mmb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mmb_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mmb_out_t             out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic signed [ELEM_W-1:0] a_elems [DEF_MAX_M][DEF_MAX_K];
  logic signed [ELEM_W-1:0] b_elems [DEF_MAX_K][DEF_MAX_N];
  logic [REG_W-1:0] m_size, k_size, n_size;
  mmb_out_t sums_q[$];

  function automatic int unsigned clamp_dim(logic [REG_W-1:0] v, int unsigned lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  // model one request: in-range writes update the stores, reads push an expected result
  function automatic void predict_request(mmb_in_t req);
    int unsigned m, k, n;
    longint acc;
    mmb_out_t res;
    m = clamp_dim(m_size, DEF_MAX_M);
    k = clamp_dim(k_size, DEF_MAX_K);
    n = clamp_dim(n_size, DEF_MAX_N);
    case (req.command)
      CMD_WRITE_A: begin
        if (req.row_index < m && req.col_index < k)
          a_elems[req.row_index][req.col_index] = req.elem_value;
      end
      CMD_WRITE_B: begin
        if (req.row_index < k && req.col_index < n)
          b_elems[req.row_index][req.col_index] = req.elem_value;
      end
      CMD_READ: begin
        res = '0;
        if (req.row_index < m && req.col_index < n) begin
          acc = 0;
          for (int t = 0; t < k; t++)
            acc += longint'(a_elems[req.row_index][t]) * longint'(b_elems[t][req.col_index]);
          res.product_sum = acc[SUM_W-1:0];
          res.in_range = 1'b1;
        end
        sums_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // watch config, requests and results at each edge
  always @(posedge clk) begin
    mmb_out_t exp_res;
    if (rst) begin
      m_size = SIZE_RESET;
      k_size = SIZE_RESET;
      n_size = SIZE_RESET;
      sums_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS_M:  m_size = cfg_data;
          REG_INNER_K: k_size = cfg_data;
          REG_COLS_N:  n_size = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_request(in_data);
      if (out_valid && !out_stall) begin
        if (sums_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result sum=%0d in_range=%0b", $realtime,
                     out_data.product_sum, out_data.in_range);
          fail_count = fail_count + 1;
        end else begin
          exp_res = sums_q.pop_front();
          if (exp_res.product_sum !== out_data.product_sum ||
              exp_res.in_range !== out_data.in_range) begin
            if (fail_count < 10)
              $display("%0t: sum exp %0d got %0d, in_range exp %0b got %0b", $realtime,
                       exp_res.product_sum, out_data.product_sum,
                       exp_res.in_range, out_data.in_range);
            fail_count = fail_count + 1;
          end
        end
      end
      pending <= sums_q.size();
    end
  end

endmodule

// File: verif/tb.sv
// stimulus and verdict for the bounded matrix multiply block
`timescale 1ns / 1ps
module tb;
  import mmb_pkg::*;

  // rows of A and columns of B that are filled and read in range
  localparam int unsigned FILL_LINES = 2;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  mmb_in_t in_data;
  mmb_out_t out_data;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  int fail_count, pending;
  bit quiet;
  int unsigned m_cur, k_cur, n_cur;

  matrix_multiply_bounded_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mmb_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("matrix_multiply_bounded_unit: mismatch");
    $finish;
  end

  // receiver stall in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_stall = 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // send one request and wait until accepted
  task automatic send_req(logic [CMD_W-1:0] cmd, int unsigned row, int unsigned col,
                          logic signed [ELEM_W-1:0] val);
    bit taken;
    if (!quiet && $urandom_range(0, 15) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data.command = cmd;
    in_data.row_index = row[IDX_W-1:0];
    in_data.col_index = col[IDX_W-1:0];
    in_data.elem_value = val;
    forever begin
      #1 taken = !in_stall;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
    end
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // wait out every result and any trailing writes, then set all sizes
  task automatic set_sizes(int unsigned m, int unsigned k, int unsigned n);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    for (int r = 0; r < 3; r++) begin
      cfg_write = 1'b1;
      case (r)
        0: begin cfg_index = REG_ROWS_M;  cfg_data = REG_W'(m); end
        1: begin cfg_index = REG_INNER_K; cfg_data = REG_W'(k); end
        default: begin cfg_index = REG_COLS_N; cfg_data = REG_W'(n); end
      endcase
      @(negedge clk);
    end
    cfg_write = 1'b0;
    m_cur = (m > 64) ? 64 : m;
    k_cur = (k > 64) ? 64 : k;
    n_cur = (n > 64) ? 64 : n;
  endtask

  // fill the first rows of A and columns of B that reads may touch
  task automatic fill_stores(bit extreme);
    for (int i = 0; i < ((m_cur < FILL_LINES) ? m_cur : FILL_LINES); i++)
      for (int t = 0; t < k_cur; t++)
        send_req(CMD_WRITE_A, i, t, extreme ? 16'sh8000 : rand_elem());
    for (int j = 0; j < ((n_cur < FILL_LINES) ? n_cur : FILL_LINES); j++)
      for (int t = 0; t < k_cur; t++)
        send_req(CMD_WRITE_B, t, j, extreme ? 16'sh8000 : rand_elem());
  endtask

  // random mix; in-range reads stay inside the filled rows and columns
  task automatic random_traffic(int count);
    int unsigned sel;
    for (int q = 0; q < count; q++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40 && m_cur > 0 && k_cur > 0 && n_cur > 0) begin
        if ($urandom_range(0, 1))
          send_req(CMD_WRITE_A, $urandom_range(0, m_cur - 1), $urandom_range(0, k_cur - 1),
                   rand_elem());
        else
          send_req(CMD_WRITE_B, $urandom_range(0, k_cur - 1), $urandom_range(0, n_cur - 1),
                   rand_elem());
      end else if (sel < 55) begin
        send_req($urandom_range(0, 1) ? CMD_WRITE_A : CMD_WRITE_B, $urandom_range(0, 63),
                 $urandom_range(0, 63), rand_elem());
      end else if (sel < 95) begin
        if ($urandom_range(0, 9) < 7 && m_cur > 0 && n_cur > 0)
          send_req(CMD_READ, $urandom_range(0, ((m_cur < FILL_LINES) ? m_cur : FILL_LINES) - 1),
                   $urandom_range(0, ((n_cur < FILL_LINES) ? n_cur : FILL_LINES) - 1),
                   rand_elem());
        else if (m_cur < 64)
          send_req(CMD_READ, $urandom_range(m_cur, 63), $urandom_range(0, 63), rand_elem());
        else if (n_cur < 64)
          send_req(CMD_READ, $urandom_range(0, 63), $urandom_range(n_cur, 63), rand_elem());
        else
          send_req(CMD_READ, $urandom_range(0, FILL_LINES - 1),
                   $urandom_range(0, FILL_LINES - 1), rand_elem());
      end else begin
        send_req(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), rand_elem());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = REG_ROWS_M;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 2x2 with extreme values, out-of-range traffic, unused command
    set_sizes(2, 2, 2);
    send_req(CMD_WRITE_A, 0, 0, 16'sh8000);
    send_req(CMD_WRITE_A, 0, 1, 16'sh7fff);
    send_req(CMD_WRITE_A, 1, 0, -16'sd1);
    send_req(CMD_WRITE_A, 1, 1, 16'sd1);
    send_req(CMD_WRITE_B, 0, 0, 16'sh8000);
    send_req(CMD_WRITE_B, 1, 0, 16'sh7fff);
    send_req(CMD_WRITE_B, 0, 1, 16'sh7fff);
    send_req(CMD_WRITE_B, 1, 1, 16'sh8000);
    send_req(CMD_READ, 0, 0, 16'sd0);
    send_req(CMD_READ, 0, 1, 16'sh7fff);
    send_req(CMD_READ, 1, 0, 16'sd0);
    send_req(CMD_READ, 1, 1, 16'sh8000);
    send_req(CMD_READ, 2, 0, 16'sd0);
    send_req(CMD_READ, 0, 2, 16'sd0);
    send_req(CMD_READ, 63, 63, -16'sd1);
    send_req(CMD_WRITE_A, 63, 63, 16'sd5);
    send_req(CMD_WRITE_A, 0, 2, 16'sd5);
    send_req(CMD_WRITE_B, 2, 0, 16'sd5);
    send_req(CMD_WRITE_B, 0, 2, 16'sd5);
    send_req(CMD_UNUSED, 63, 63, -16'sd1);
    send_req(CMD_READ, 1, 1, 16'sd0);
    send_req(CMD_READ, 0, 0, 16'sd0);

    // sizes above the maximum with largest sums
    set_sizes(127, 127, 127);
    fill_stores(1'b1);
    send_req(CMD_READ, 0, 0, 16'sd0);
    send_req(CMD_READ, 1, 1, 16'sd0);
    random_traffic(60);

    // single element, zero sizes and the built maximum
    set_sizes(1, 1, 1);
    fill_stores(1'b0);
    random_traffic(40);
    set_sizes(0, 3, 3);
    random_traffic(60);
    set_sizes(3, 0, 3);
    random_traffic(60);
    set_sizes(3, 3, 0);
    random_traffic(60);
    set_sizes(64, 64, 64);
    random_traffic(60);

    // random small sizes; last phase runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      set_sizes($urandom_range(1, 12), $urandom_range(1, 16), $urandom_range(1, 12));
      if (ph == 5) quiet = 1'b1;
      fill_stores(1'b0);
      random_traffic(60);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("matrix_multiply_bounded_unit: match");
    else
      $display("matrix_multiply_bounded_unit: mismatch");
    $finish;
  end

endmodule
